/* hdl/asgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pkg
// shared types and constants of the sgr line parser
// ----------------------------------------------------------------------------
package asgr_pkg;

  localparam int AttrW = 39;
  localparam int ParW  = 16;

  typedef logic [AttrW-1:0] attrs_t;
  typedef logic [ParW-1:0]  param_t;

  localparam logic [7:0] ChEsc  = 8'h1B;
  localparam logic [7:0] ChLbr  = 8'h5B;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChCol  = 8'h3A;
  localparam logic [7:0] ChM    = 8'h6D;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam param_t     Sat16  = 16'hFFFF;

  localparam int FgLo = 7;
  localparam int BgLo = 23;

  // controller to datapath
  typedef struct packed {
    logic accum_digit;   // fold digit into number
    logic accum_clear;
    logic push;          // push number into store
    logic seq_clear;     // drop param count
    logic walk_start;    // load walk registers
    logic walk_step;     // fetch a param or apply one code
    logic walk_commit;   // write back attrs, update peak
    logic mark_first;    // check for first non-blank
    logic line_clear;
  } asgr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
  } asgr_sts_t;

  function automatic logic signed [3:0] weight_of(attrs_t a);
    logic signed [3:0] w;
    w = 4'sd0;
    if (a[0]) w = w + 4'sd2;
    if (a[4]) w = w + 4'sd3;
    if (a[6]) w = w + 4'sd2;
    if (a[1]) w = w - 4'sd1;
    return w;
  endfunction

endpackage

/* hdl/asgr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_in_if / asgr_out_if
// valid-ready channels of the sgr line parser
// ----------------------------------------------------------------------------
interface asgr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;
  modport source (output valid, func, ch, input ready);
  modport sink (input valid, func, ch, output ready);
endinterface

interface asgr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  plain_char;
  logic        char_valid;
  logic        line_done;
  logic [38:0] start_attrs;
  logic [38:0] heavy_attrs;
  logic [3:0]  peak_weight;
  logic        params_dropped;
  modport source (output valid, plain_char, char_valid, line_done, start_attrs,
                  heavy_attrs, peak_weight, params_dropped, input ready);
  modport sink (input valid, plain_char, char_valid, line_done, start_attrs,
                heavy_attrs, peak_weight, params_dropped, output ready);
endinterface

/* hdl/asgr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module asgr_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/asgr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_datapath
// number accumulation, parameter store, sgr walk and line attribute state
// ----------------------------------------------------------------------------
module asgr_datapath #(
  parameter int MaxParams = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  asgr_pkg::asgr_cmd_t cmd,
  output asgr_pkg::asgr_sts_t sts,
  input  logic [7:0]          ch,
  output asgr_pkg::attrs_t    first_attrs,
  output asgr_pkg::attrs_t    best_attrs,
  output logic                overflow_seen
);
  import asgr_pkg::*;

  localparam int AW = $clog2(MaxParams);
  localparam int CW = $clog2(MaxParams + 1);

  param_t           number_accum;
  logic [CW-1:0]    param_count;
  attrs_t           current_attrs;
  logic             seeking_first;
  attrs_t           walk_attrs;
  logic [CW-1:0]    walk_idx;   // index of param held in the window head
  logic [CW-1:0]    fetch_idx;  // next address to read
  // window of five params: win[0] is current
  param_t           win [5];
  logic             ram_vld;

  param_t           rdata;
  param_t           nv_mul;
  logic [19:0]      nv;
  logic             push_ok;

  assign push_ok = param_count < CW'(MaxParams);
  assign nv_mul = number_accum;
  assign nv = {nv_mul, 3'b000} + {2'b00, nv_mul, 1'b0} + 20'(ch - 8'h30);

  asgr_ram #(.Width(ParW), .Depth(MaxParams)) u_store (
    .clk   (clk),
    .we    (cmd.push && push_ok),
    .waddr (param_count[AW-1:0]),
    .wdata (number_accum),
    .raddr (fetch_idx[AW-1:0]),
    .rdata (rdata)
  );

  // number of params valid from walk_idx on
  logic [CW-1:0] remain;
  logic [CW:0]   filled;   // params loaded into window (from walk_idx)
  assign remain = param_count - walk_idx;

  // walk step: need window filled up to min(5, remain) params
  logic need_more;
  logic [CW:0] want;
  assign want = ({1'b0, remain} > (CW+1)'(5)) ? (CW+1)'(5) : {1'b0, remain};
  assign need_more = filled < want;
  assign sts.walk_done = (walk_idx >= param_count) && !ram_vld;

  function automatic attrs_t put_fg(attrs_t a, param_t v, logic set);
    attrs_t r;
    r = a;
    r[FgLo +: 16] = set ? v : 16'd0;
    r[5] = set;
    return r;
  endfunction
  function automatic attrs_t put_bg(attrs_t a, param_t v, logic set);
    attrs_t r;
    r = a;
    r[BgLo +: 16] = set ? v : 16'd0;
    r[6] = set;
    return r;
  endfunction

  attrs_t        step_attrs;
  logic [2:0]    step_adv;
  always_comb begin
    param_t v;
    logic   n1, n2, n4;
    v  = win[0];
    n1 = remain > CW'(1);
    n2 = remain > CW'(2);
    n4 = remain > CW'(4);
    step_attrs = walk_attrs;
    step_adv   = 3'd1;
    if (v == 16'd0) step_attrs = '0;
    else if (v == 16'd1) step_attrs[0] = 1'b1;
    else if (v == 16'd2) step_attrs[1] = 1'b1;
    else if (v == 16'd3) step_attrs[2] = 1'b1;
    else if (v == 16'd4) step_attrs[3] = 1'b1;
    else if (v == 16'd7) step_attrs[4] = 1'b1;
    else if (v == 16'd22) step_attrs[1:0] = 2'b00;
    else if (v == 16'd27) step_attrs[4] = 1'b0;
    else if ((v >= 16'd30 && v <= 16'd37) || (v >= 16'd90 && v <= 16'd97))
      step_attrs = put_fg(walk_attrs, v, 1'b1);
    else if (v == 16'd39) step_attrs = put_fg(walk_attrs, 16'd0, 1'b0);
    else if ((v >= 16'd40 && v <= 16'd47) || (v >= 16'd100 && v <= 16'd107))
      step_attrs = put_bg(walk_attrs, v, 1'b1);
    else if (v == 16'd49) step_attrs = put_bg(walk_attrs, 16'd0, 1'b0);
    else if ((v == 16'd38 || v == 16'd48) && n1) begin
      if (win[1] == 16'd5 && n2) begin
        step_attrs = (v == 16'd38) ? put_fg(walk_attrs, win[2], 1'b1)
                                   : put_bg(walk_attrs, win[2], 1'b1);
        step_adv = 3'd3;
      end else if (win[1] == 16'd2 && n4) begin
        step_attrs = (v == 16'd38) ? put_fg(walk_attrs, 16'd256, 1'b1)
                                   : put_bg(walk_attrs, 16'd256, 1'b1);
        step_adv = 3'd5;
      end
    end
  end

  logic do_step;
  assign do_step = cmd.walk_step && !need_more && !ram_vld && (walk_idx < param_count);

  always_ff @(posedge clk) begin
    if (rst || cmd.line_clear) begin
      number_accum  <= '0;
      param_count   <= '0;
      current_attrs <= '0;
      first_attrs   <= '0;
      best_attrs    <= '0;
      seeking_first <= 1'b1;
      overflow_seen <= 1'b0;
      ram_vld       <= 1'b0;
      walk_idx      <= '0;
      fetch_idx     <= '0;
      filled        <= '0;
    end else begin
      if (cmd.accum_clear) number_accum <= '0;
      else if (cmd.accum_digit)
        number_accum <= (nv > 20'(Sat16)) ? Sat16 : nv[15:0];
      else if (cmd.push) number_accum <= '0;
      if (cmd.push) begin
        if (push_ok) param_count <= param_count + CW'(1);
        else overflow_seen <= 1'b1;
      end
      if (cmd.seq_clear) param_count <= '0;
      if (cmd.mark_first && seeking_first && ch != ChSp && ch != ChTab) begin
        first_attrs   <= current_attrs;
        seeking_first <= 1'b0;
      end
      if (cmd.walk_start) begin
        walk_attrs <= current_attrs;
        walk_idx   <= '0;
        fetch_idx  <= '0;
        filled     <= '0;
        ram_vld    <= 1'b0;
      end else if (cmd.walk_step) begin
        // one read in flight at a time
        if (ram_vld) begin
          win[filled[2:0]] <= rdata;
          filled  <= filled + (CW+1)'(1);
          ram_vld <= 1'b0;
        end else if (need_more) begin
          ram_vld   <= 1'b1;
          fetch_idx <= fetch_idx + CW'(1);
        end else if (do_step) begin
          walk_attrs <= step_attrs;
          walk_idx   <= walk_idx + CW'(step_adv);
          fetch_idx  <= walk_idx + CW'(step_adv);
          filled     <= '0;
        end
      end
      if (cmd.walk_commit) begin
        current_attrs <= walk_attrs;
        if (weight_of(walk_attrs) > weight_of(best_attrs)) best_attrs <= walk_attrs;
      end
    end
  end

  // fetch address must point at walk_idx+filled when issuing
  // (fetch_idx tracks it since reads are issued in order)
endmodule

/* hdl/asgr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_ctrl
// escape phase tracking, handshakes and walk sequencing
// ----------------------------------------------------------------------------
module asgr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [7:0]          ch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                res_char,
  output logic                res_done,
  output logic [7:0]          res_byte,
  output asgr_pkg::asgr_cmd_t cmd,
  input  asgr_pkg::asgr_sts_t sts
);
  import asgr_pkg::*;

  typedef enum logic [2:0] {
    S_GROUND, S_ESC, S_CSI, S_WALK, S_COMMIT
  } state_t;

  state_t state;
  logic   acc;
  logic   is_digit;

  assign in_ready = !rst && (state == S_GROUND || state == S_ESC || state == S_CSI)
                    && (!out_valid || out_ready);
  assign acc = in_valid && in_ready;
  assign is_digit = ch >= 8'h30 && ch <= 8'h39;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_WALK:   cmd.walk_step   = 1'b1;
      S_COMMIT: begin
        cmd.walk_commit = 1'b1;
        cmd.seq_clear   = 1'b1;
      end
      default: begin
        if (acc) begin
          if (func) cmd.line_clear = 1'b1;
          else if (state == S_ESC) begin
            cmd.seq_clear   = (ch == ChLbr);
            cmd.accum_clear = (ch == ChLbr);
          end else if (state == S_CSI) begin
            if (is_digit) cmd.accum_digit = 1'b1;
            else begin
              cmd.push = 1'b1;
              cmd.walk_start = (ch == ChM);
              cmd.seq_clear  = 1'b0;
            end
          end else if (ch != ChEsc) cmd.mark_first = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_GROUND;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_WALK:   if (sts.walk_done) state <= S_COMMIT;
        S_COMMIT: state <= S_GROUND;
        default: begin
          if (acc) begin
            if (func) begin
              state     <= S_GROUND;
              out_valid <= 1'b1;
              res_done  <= 1'b1;
              res_char  <= 1'b0;
              res_byte  <= '0;
            end else if (state == S_ESC) begin
              state <= (ch == ChLbr) ? S_CSI : S_GROUND;
            end else if (state == S_CSI) begin
              if (!is_digit && ch != ChSemi && ch != ChCol)
                state <= (ch == ChM) ? S_WALK : S_GROUND;
            end else if (ch == ChEsc) begin
              state <= S_ESC;
            end else begin
              out_valid <= 1'b1;
              res_done  <= 1'b0;
              res_char  <= 1'b1;
              res_byte  <= ch;
            end
          end
        end
      endcase
    end
  end

  // a final other than m leaves the param count as it is
  // (it is cleared when the next sequence opens or a line ends)
endmodule

/* hdl/ansi_sgr_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_line_parser
// streaming ansi escape / sgr parser for one terminal line
// ----------------------------------------------------------------------------
// Words are accepted back to back while results are taken, except a final
// 'm', after which the controller walks the stored parameters through the
// single read port of the parameter ram: every applied code first reloads a
// window of up to five parameters, one read in flight at a time, and is then
// applied, and the walk ends in a commit state that writes the attributes
// back. The input is held for the whole walk. The result of a word is
// registered; the next word is accepted in the cycle the pending result is
// taken, so a result that is not taken holds the input.
module ansi_sgr_line_parser #(
  parameter int MAX_PARAMS = 16
) (
  input logic        clk,
  input logic        rst,
  asgr_in_if.sink    in_ch,
  asgr_out_if.source out_ch
);
  import asgr_pkg::*;

  asgr_cmd_t cmd;
  asgr_sts_t sts;
  attrs_t    first_attrs, best_attrs;
  logic      overflow_seen;
  logic      res_char, res_done;
  logic [7:0] res_byte;
  attrs_t    rep_first, rep_best;
  logic      rep_ovf;

  asgr_ctrl u_ctrl (
    .clk (clk), .rst (rst),
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .func (in_ch.func), .ch (in_ch.ch),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .res_char (res_char), .res_done (res_done), .res_byte (res_byte),
    .cmd (cmd), .sts (sts)
  );

  asgr_datapath #(.MaxParams(MAX_PARAMS)) u_dp (
    .clk (clk), .rst (rst), .cmd (cmd), .sts (sts), .ch (in_ch.ch),
    .first_attrs (first_attrs), .best_attrs (best_attrs),
    .overflow_seen (overflow_seen)
  );

  // snapshot line report before the restart clears it
  always_ff @(posedge clk) begin
    if (cmd.line_clear) begin
      rep_first <= first_attrs;
      rep_best  <= best_attrs;
      rep_ovf   <= overflow_seen;
    end
  end

  assign out_ch.plain_char     = res_byte;
  assign out_ch.char_valid     = res_char;
  assign out_ch.line_done      = res_done;
  assign out_ch.start_attrs    = res_done ? rep_first : '0;
  assign out_ch.heavy_attrs    = res_done ? rep_best : '0;
  assign out_ch.peak_weight    = res_done ? weight_of(rep_best) : 4'sd0;
  assign out_ch.params_dropped = res_done & rep_ovf;
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// sgr line parser bench: directed lines, random well-formed escapes and noise,
// a scoreboard of echoed bytes and end-of-line reports, and back-pressure
// ----------------------------------------------------------------------------
module tb_top;
  import asgr_pkg::*;

  localparam int MaxPar = 16;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [7:0] plain_char;
    logic       char_valid;
    logic       line_done;
    attrs_t     start_attrs;
    attrs_t     heavy_attrs;
    logic [3:0] peak_weight;
    logic       params_dropped;
  } line_result_t;

  typedef enum logic [1:0] {PhGround = 2'd0, PhEsc = 2'd1, PhCsi = 2'd2} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  asgr_in_if  in_ch ();
  asgr_out_if out_ch ();

  ansi_sgr_line_parser #(.MAX_PARAMS(MaxPar)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  phase_t     pr_phase;
  param_t     pr_store [MaxPar];
  int         pr_count;
  int         pr_accum;
  attrs_t     pr_cur, pr_first, pr_best;
  bit         pr_seeking, pr_overflow;

  line_result_t pending_results[$];
  int  mismatches = 0;
  int  sent_words = 0;
  bit  tx_idle_on = 1;
  bit  rx_idle_on = 1;
  bit  rx_hold = 0;
  int  watch_count = 0;

  function automatic int weight(attrs_t a);
    int w;
    w = 0;
    if (a[0]) w += 2;
    if (a[4]) w += 3;
    if (a[6]) w += 2;
    if (a[1]) w -= 1;
    return w;
  endfunction

  function automatic attrs_t set_color(attrs_t a, bit bg, int v, bit en);
    attrs_t r;
    r = a;
    if (bg) begin
      r[BgLo +: 16] = en ? 16'(v) : 16'd0;
      r[6] = en;
    end else begin
      r[FgLo +: 16] = en ? 16'(v) : 16'd0;
      r[5] = en;
    end
    return r;
  endfunction

  task automatic line_reset();
    pr_phase = PhGround;
    pr_count = 0;
    pr_accum = 0;
    pr_cur = '0;
    pr_first = '0;
    pr_best = '0;
    pr_seeking = 1;
    pr_overflow = 0;
  endtask

  task automatic queue_result(line_result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic push_number();
    if (pr_count < MaxPar) begin
      pr_store[pr_count] = param_t'(pr_accum);
      pr_count++;
    end else begin
      pr_overflow = 1;
    end
    pr_accum = 0;
  endtask

  task automatic apply_codes();
    attrs_t a;
    int v, md;
    a = pr_cur;
    for (int j = 0; j < pr_count; j++) begin
      v = pr_store[j];
      if (v == 0) a = '0;
      else if (v == 1) a[0] = 1;
      else if (v == 2) a[1] = 1;
      else if (v == 3) a[2] = 1;
      else if (v == 4) a[3] = 1;
      else if (v == 7) a[4] = 1;
      else if (v == 22) a[1:0] = 2'b00;
      else if (v == 27) a[4] = 0;
      else if ((v >= 30 && v <= 37) || (v >= 90 && v <= 97))
        a = set_color(a, 1'b0, v, 1'b1);
      else if (v == 39) a = set_color(a, 1'b0, 0, 1'b0);
      else if ((v >= 40 && v <= 47) || (v >= 100 && v <= 107))
        a = set_color(a, 1'b1, v, 1'b1);
      else if (v == 49) a = set_color(a, 1'b1, 0, 1'b0);
      else if ((v == 38 || v == 48) && j + 1 < pr_count) begin
        md = pr_store[j+1];
        if (md == 5 && j + 2 < pr_count) begin
          a = set_color(a, v == 48, pr_store[j+2], 1'b1);
          j += 2;
        end else if (md == 2 && j + 4 < pr_count) begin
          a = set_color(a, v == 48, 256, 1'b1);
          j += 4;
        end
      end
    end
    pr_cur = a;
    if (weight(pr_cur) > weight(pr_best)) pr_best = pr_cur;
  endtask

  // work out what one accepted word produces
  task automatic predict_word(bit func, logic [7:0] ch);
    line_result_t r;
    r = '0;
    if (func) begin
      r.line_done = 1;
      r.start_attrs = pr_first;
      r.heavy_attrs = pr_best;
      r.peak_weight = 4'(weight(pr_best));
      r.params_dropped = pr_overflow;
      queue_result(r);
      line_reset();
    end else if (pr_phase == PhEsc) begin
      if (ch == ChLbr) begin
        pr_phase = PhCsi;
        pr_count = 0;
        pr_accum = 0;
      end else begin
        pr_phase = PhGround;
      end
    end else if (pr_phase == PhCsi) begin
      if (ch >= "0" && ch <= "9") begin
        pr_accum = pr_accum * 10 + (ch - "0");
        if (pr_accum > 65535) pr_accum = 65535;
      end else if (ch == ChSemi || ch == ChCol) begin
        push_number();
      end else begin
        push_number();
        if (ch == ChM) apply_codes();
        pr_phase = PhGround;
        pr_count = 0;
        pr_accum = 0;
      end
    end else if (ch == ChEsc) begin
      pr_phase = PhEsc;
    end else begin
      if (pr_seeking && ch != ChSp && ch != ChTab) begin
        pr_first = pr_cur;
        pr_seeking = 0;
      end
      r.plain_char = ch;
      r.char_valid = 1;
      queue_result(r);
    end
  endtask

  task automatic send_word(bit func, logic [7:0] ch);
    int gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.ch <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
    predict_word(func, ch);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic send_sgr(string body);
    send_word(1'b0, ChEsc);
    send_word(1'b0, ChLbr);
    send_text(body);
    send_word(1'b0, ChM);
  endtask

  task automatic end_line();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic go_quiet();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_text(" \tA");
    send_sgr("");
    send_sgr("1;2;3;4;7");
    send_text("x");
    send_sgr("22;27;31;42");
    send_sgr("38;5;65535;48:2:1:2:3");
    end_line();
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_sgr("99999;;39;49;97;107;38;7");
    send_word(1'b0, ChEsc);
    send_word(1'b0, "(");
    send_word(1'b0, ChEsc);
    send_word(1'b0, ChLbr);
    send_text("1;1;1;1;1;1;1;1;1;1;1;1;1;1;1;1;1;2J");
    send_sgr("48;9;1;38;2;1");
    send_word(1'b0, ChEsc);
    send_word(1'b0, ChLbr);
    send_text("7");
    end_line();
  endtask

  function automatic string rand_code();
    int k;
    k = $urandom_range(0, 11);
    case (k)
      0: return "0";
      1: return $sformatf("%0d", $urandom_range(1, 7));
      2: return $sformatf("%0d", 22 + 5 * $urandom_range(0, 1));
      3: return $sformatf("%0d", $urandom_range(30, 49));
      4: return $sformatf("%0d", $urandom_range(90, 107));
      5: return $sformatf("38;5;%0d", $urandom_range(0, 300));
      6: return $sformatf("48:5:%0d", $urandom_range(0, 255));
      7: return $sformatf("%0d;2;%0d;%0d;%0d", $urandom_range(0, 1) ? 38 : 48,
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
      8: return $sformatf("%0d", $urandom_range(0, 70000));
      9: return "";
      10: return $sformatf("%0d;%0d", $urandom_range(0, 1) ? 38 : 48, $urandom_range(0, 6));
      default: return "1";
    endcase
  endfunction

  task automatic random_line();
    int n, m;
    string body;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          m = $urandom_range(1, 4);
          body = rand_code();
          for (int k = 1; k < m; k++) body = {body, ($urandom_range(0, 3) == 0) ? ":" : ";",
                                             rand_code()};
          if ($urandom_range(0, 15) == 0)
            for (int k = 0; k < 18; k++) body = {body, ";1"};
          send_sgr(body);
        end
        4, 5, 6: send_word(1'b0, $urandom_range(0, 1) ? ChSp : 8'($urandom_range(32, 126)));
        7: send_word(1'b0, 8'($urandom_range(0, 255)));
        8: begin
          send_word(1'b0, ChEsc);
          send_word(1'b0, 8'($urandom_range(0, 255)));
        end
        default: send_word(1'b0, ChTab);
      endcase
    end
    end_line();
  endtask

  task automatic test_random(int words);
    int start_cnt;
    start_cnt = sent_words;
    while (sent_words - start_cnt < words) begin
      random_line();
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 1;
    for (int i = 0; i < 30; i++) send_word(1'b0, 8'("a" + i % 26));
    end_line();
    wait_drain();
  endtask

  // receiver side: random ready bursts and one long hold
  initial begin
    int hold_cycles;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 200) begin
          @(posedge clk);
          hold_cycles++;
        end
        rx_hold = 0;
        out_ch.ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    line_result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.plain_char, out_ch.char_valid, out_ch.line_done, out_ch.start_attrs,
             out_ch.heavy_attrs, out_ch.peak_weight, out_ch.params_dropped};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: char %h/%h cv %b/%b ld %b/%b start %h/%h ",
                      "peak %h/%h w %h/%h d %b/%b"},
                     want.plain_char, got.plain_char, want.char_valid, got.char_valid,
                     want.line_done, got.line_done, want.start_attrs, got.start_attrs,
                     want.heavy_attrs, got.heavy_attrs, want.peak_weight, got.peak_weight,
                     want.params_dropped, got.params_dropped);
        end
      end
    end
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      watch_count <= 0;
    else
      watch_count <= watch_count + 1;
    if (watch_count >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.func <= 1'b0;
    in_ch.ch <= 8'h00;
    line_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(380);
    wait_drain();
    tx_idle_on = 0;
    rx_idle_on = 0;
    test_random(190);
    wait_drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/asgr_pkg.sv
hdl/asgr_if.sv
hdl/asgr_ram.sv
hdl/asgr_datapath.sv
hdl/asgr_ctrl.sv
hdl/ansi_sgr_line_parser.sv
tb/sv/tb_top.sv
